@@ design/sre_pkg.sv @@
// Shared types and constants for the sprite run-length decoder.
// Parser phase encoding, error codes, register indexes and reset values.
// No dependencies.
package sre_pkg;

  // Parser phases, one per byte position in the sprite stream
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SIZEHI = 3'd1,
    PH_RUNLO  = 3'd2,
    PH_RUNHI  = 3'd3,
    PH_RED    = 3'd4,
    PH_GREEN  = 3'd5,
    PH_BLUE   = 3'd6
  } phase_e;

  // Error codes carried with the end-of-sprite item
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_SIZE     = 2'd1,
    ERR_RUN      = 2'd2,
    ERR_RESERVED = 2'd3
  } err_e;

  // Configuration register indexes
  localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;
  localparam logic [1:0] REG_MAX_RUN     = 2'd3;

  // Register reset values
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd3500;
  localparam logic [15:0] MAX_RUN_RST     = 16'd3076;

  // Default sprite row width in pixels
  localparam int unsigned SPRITE_WIDTH_DFLT = 32;

endpackage

@@ design/sprite_rle_decoder.sv @@
// Sprite run-length decoder: one stream byte in, at most one pixel/end item out.
// Depends on sre_pkg (phases, error codes, register indexes, reset values).
//
// Usage:
//   Slave stream: tdata = data_byte, tuser = sprite_start. One byte per item.
//   Master stream: one item per decoded pixel and/or sprite end; tlast marks
//   the end of a sprite, tuser carries has_pixel and the error code.
//   Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 origin_x, 1 origin_y, 2 max_payload_bytes, 3 max_run_length);
//   write only while the decoder is idle.
// Throughput: one byte per clock cycle unless a held result is not taken;
// the parser state machine updates once per byte and the pixel position
// divide is spread over the red and green bytes of each triple (one constant multiply per byte).
// Output: a result is registered and appears on the master side in the
// cycle after the byte that causes it is accepted.
// Reset: registers return to 0, 0, 3500, 3076 and the parser goes idle;
// no clearing pass is needed, input is taken from the first cycle.
// Stall: a single output register holds a result; the next byte is taken
// in the same cycle the held result drains, so a stalled receiver holds
// the input side only while the output register is full and not taken.
module sprite_rle_decoder
  import sre_pkg::*;
#(
  parameter int unsigned SpriteWidth = SPRITE_WIDTH_DFLT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,  // [0] sprite_start
  // Result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [11:0] pixel_x, [23:12] pixel_y,
                                     // [31:24] red, [39:32] green, [47:40] blue
  output logic [2:0]  m_axis_tuser,  // [0] has_pixel, [2:1] error_code
  output logic        m_axis_tlast   // sprite_end
);

  // Reciprocal for exact 16-bit division by the row width
  localparam int unsigned ShiftW = 16 + $clog2(SpriteWidth);
  localparam longint unsigned RecipL =
    ((64'd1 << ShiftW) + 64'(SpriteWidth) - 64'd1) / 64'(SpriteWidth);
  localparam logic [16:0] Recip   = 17'(RecipL);
  localparam int unsigned RemW    = (SpriteWidth > 1) ? $clog2(SpriteWidth) : 1;
  localparam logic [15:0] WidthC  = 16'(SpriteWidth);

  // Configuration registers
  logic [10:0] origin_x_q, origin_y_q;
  logic [15:0] max_payload_q, max_run_q;

  // Parser state
  phase_e      phase_q, phase_d;
  logic [15:0] size_q, size_d;
  logic [15:0] cons_q, cons_d;
  logic [15:0] idx_q, idx_d;
  logic        transp_q, transp_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  lo_q, lo_d;
  logic [7:0]  red_q, red_d;
  logic [7:0]  green_q, green_d;
  logic [15:0] quot_q, quot_d;
  logic [RemW-1:0] rem_q, rem_d;

  // Result register
  logic        out_valid_q;
  logic [47:0] out_data_q, out_data_d;
  logic [2:0]  out_user_q, out_user_d;
  logic        out_last_q;

  logic        in_fire, out_load;
  logic        res_pix, res_end;
  err_e        res_err;
  logic [15:0] run_val, cons_inc, left_dec, size_new;
  logic        run_ends;
  logic [32:0] recip_prod;
  logic [15:0] quot_w;
  logic [15:0] rem_full;
  logic [11:0] px, py;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      max_payload_q <= MAX_PAYLOAD_RST;
      max_run_q     <= MAX_RUN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X:    origin_x_q    <= cfg_data_i[10:0];
        REG_ORIGIN_Y:    origin_y_q    <= cfg_data_i[10:0];
        REG_MAX_PAYLOAD: max_payload_q <= cfg_data_i;
        REG_MAX_RUN:     max_run_q     <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // Pixel position divide: quotient on the red byte, remainder on the green byte
  assign recip_prod = 33'(idx_q) * 33'(Recip);
  assign quot_w     = 16'(recip_prod >> ShiftW);
  assign rem_full   = idx_q - 16'(quot_q * WidthC);

  // Pixel coordinates from the registered quotient and remainder
  assign px = {1'b0, origin_x_q} + 12'(rem_q);
  assign py = {1'b0, origin_y_q} + quot_q[11:0];

  // Shared byte arithmetic
  assign run_val  = {s_axis_tdata, lo_q};
  assign size_new = {s_axis_tdata, lo_q};
  assign cons_inc = (cons_q == 16'hFFFF) ? cons_q : cons_q + 16'd1;
  assign left_dec = left_q - 16'd1;
  assign run_ends = ({1'b0, cons_inc} + 17'd1) >= {1'b0, size_q};

  // Parser next state and result
  always_comb begin
    phase_d  = phase_q;
    size_d   = size_q;
    cons_d   = cons_q;
    idx_d    = idx_q;
    transp_d = transp_q;
    left_d   = left_q;
    lo_d     = lo_q;
    red_d    = red_q;
    green_d  = green_q;
    quot_d   = quot_q;
    rem_d    = rem_q;
    res_pix  = 1'b0;
    res_end  = 1'b0;
    res_err  = ERR_NONE;

    if (s_axis_tuser[0]) begin
      // Start of a new sprite: latch the low size byte, drop any sprite in flight
      lo_d    = s_axis_tdata;
      phase_d = PH_SIZEHI;
    end else begin
      unique case (phase_q)
        PH_SIZEHI: begin
          size_d = size_new;
          if (size_new > max_payload_q) begin
            res_end = 1'b1;
            res_err = ERR_SIZE;
          end else begin
            cons_d   = '0;
            idx_d    = '0;
            transp_d = 1'b1;
            left_d   = '0;
            if (size_new <= 16'd1) res_end = 1'b1;
            else                   phase_d = PH_RUNLO;
          end
        end
        PH_RUNLO: begin
          lo_d    = s_axis_tdata;
          cons_d  = cons_inc;
          phase_d = PH_RUNHI;
        end
        PH_RUNHI: begin
          cons_d = cons_inc;
          if (run_val > max_run_q) begin
            res_end = 1'b1;
            res_err = ERR_RUN;
          end else if (transp_q || run_val == 16'd0) begin
            idx_d    = idx_q + run_val;
            transp_d = !transp_q;
            if (run_ends) res_end = 1'b1;
            else          phase_d = PH_RUNLO;
          end else begin
            left_d  = run_val;
            phase_d = PH_RED;
          end
        end
        PH_RED: begin
          red_d   = s_axis_tdata;
          cons_d  = cons_inc;
          quot_d  = quot_w;
          phase_d = PH_GREEN;
        end
        PH_GREEN: begin
          green_d = s_axis_tdata;
          cons_d  = cons_inc;
          rem_d   = rem_full[RemW-1:0];
          phase_d = PH_BLUE;
        end
        PH_BLUE: begin
          cons_d  = cons_inc;
          res_pix = 1'b1;
          idx_d   = idx_q + 16'd1;
          left_d  = left_dec;
          if (left_dec == 16'd0) begin
            transp_d = 1'b1;
            if (run_ends) res_end = 1'b1;
            else          phase_d = PH_RUNLO;
          end else begin
            phase_d = PH_RED;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
      if (res_end) phase_d = PH_IDLE;
    end
  end

  // Result payload, zeroed fields where no pixel is carried
  always_comb begin
    out_data_d = '0;
    if (res_pix) out_data_d = {s_axis_tdata, green_q, red_q, py, px};
    out_user_d = {res_err, res_pix};
  end

  assign out_load = in_fire && (res_pix || res_end);

  // Parser state registers, advance on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      size_q   <= '0;
      cons_q   <= '0;
      idx_q    <= '0;
      transp_q <= 1'b1;
      left_q   <= '0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      size_q   <= size_d;
      cons_q   <= cons_d;
      idx_q    <= idx_d;
      transp_q <= transp_d;
      left_q   <= left_d;
    end
  end

  // Byte latches and divide results
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      lo_q    <= lo_d;
      red_q   <= red_d;
      green_q <= green_d;
      quot_q  <= quot_d;
      rem_q   <= rem_d;
    end
  end

  // Output register: load on a new result, clear when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
      out_last_q <= res_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // An item without the end mark always carries a pixel
  a_nonend_has_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[0])
    else $error("result without end or pixel");

  // An error code is only reported with the end of a sprite
  a_err_with_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[2:1] != ERR_NONE) |-> m_axis_tlast)
    else $error("error code without sprite end");

  // The parser returns to idle after an end result is produced
  a_end_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && res_end |=> phase_q == PH_IDLE)
    else $error("parser not idle after sprite end");

  // An empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output register");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for sprite_rle_decoder: byte stream in, pixel/end items out.
// Predicts each output item in step with the bytes the block accepts.
// Depends on sre_pkg (phases, error codes, register indexes, reset values).
`timescale 1ns / 1ps

module tb_top;
  import sre_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef struct packed {
    logic start;
    logic [7:0] data;
  } stream_byte_t;

  typedef struct packed {
    logic        has_pixel;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        sprite_end;
    err_e        error_code;
  } sprite_out_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = REG_ORIGIN_X;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // [7:0] data_byte
  logic [0:0]  s_axis_tuser  = '0;  // [0] sprite_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [11:0] x, [23:12] y, [31:24] r, [39:32] g, [47:40] b
  logic [2:0]  m_axis_tuser;        // [0] has_pixel, [2:1] error_code
  logic        m_axis_tlast;

  sprite_rle_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Pending stream bytes and predicted decoder outputs
  stream_byte_t byte_q[$];
  sprite_out_t  decoded_q[$];

  int unsigned mismatch_cnt = 0;
  int unsigned result_cnt   = 0;
  int unsigned idle_cycles  = 0;

  // Register copies for the predictor
  logic [10:0] cfg_ox       = '0;
  logic [10:0] cfg_oy       = '0;
  logic [15:0] cfg_max_size = MAX_PAYLOAD_RST;
  logic [15:0] cfg_max_run  = MAX_RUN_RST;

  // Parser state of the predictor
  phase_e      dec_phase  = PH_IDLE;
  logic [15:0] dec_size   = '0;
  logic [15:0] dec_count  = '0;
  logic [15:0] dec_idx    = '0;
  logic [15:0] dec_left   = '0;
  logic        dec_transp = 1'b1;
  logic [7:0]  dec_lo     = '0;
  logic [7:0]  dec_red    = '0;
  logic [7:0]  dec_green  = '0;

  // Count a body byte, saturating at the top of the 16-bit range
  function automatic void bump_count();
    if (dec_count != 16'hFFFF) dec_count = dec_count + 16'd1;
  endfunction

  // A finished run closes the sprite once the body is (nearly) used up
  function automatic bit sprite_complete();
    return (int'(dec_count) + 1) >= int'(dec_size);
  endfunction

  // Advance the parser by one accepted byte and queue the item it yields
  task automatic decode_byte(input logic [7:0] b, input logic start);
    logic [15:0] run;
    sprite_out_t r;
    r = '0;
    if (start) begin
      dec_lo    = b;
      dec_phase = PH_SIZEHI;
    end else begin
      case (dec_phase)
        PH_SIZEHI: begin
          dec_size = {b, dec_lo};
          if (dec_size > cfg_max_size) begin
            r.sprite_end = 1'b1;
            r.error_code = ERR_SIZE;
          end else begin
            dec_count  = '0;
            dec_idx    = '0;
            dec_transp = 1'b1;
            dec_left   = '0;
            if (sprite_complete()) r.sprite_end = 1'b1;
            else dec_phase = PH_RUNLO;
          end
        end
        PH_RUNLO: begin
          dec_lo = b;
          bump_count();
          dec_phase = PH_RUNHI;
        end
        PH_RUNHI: begin
          run = {b, dec_lo};
          bump_count();
          if (run > cfg_max_run) begin
            r.sprite_end = 1'b1;
            r.error_code = ERR_RUN;
          end else if (dec_transp || run == 16'd0) begin
            // skip over the run and flip between transparent and solid
            dec_idx    = dec_idx + run;
            dec_transp = ~dec_transp;
            if (sprite_complete()) r.sprite_end = 1'b1;
            else dec_phase = PH_RUNLO;
          end else begin
            dec_left  = run;
            dec_phase = PH_RED;
          end
        end
        PH_RED: begin
          dec_red = b;
          bump_count();
          dec_phase = PH_GREEN;
        end
        PH_GREEN: begin
          dec_green = b;
          bump_count();
          dec_phase = PH_BLUE;
        end
        PH_BLUE: begin
          bump_count();
          r.has_pixel = 1'b1;
          r.pixel_x   = 12'(cfg_ox + dec_idx % SPRITE_WIDTH_DFLT);
          r.pixel_y   = 12'(cfg_oy + dec_idx / SPRITE_WIDTH_DFLT);
          r.red       = dec_red;
          r.green     = dec_green;
          r.blue      = b;
          dec_idx     = dec_idx + 16'd1;
          dec_left    = dec_left - 16'd1;
          if (dec_left == 16'd0) begin
            dec_transp = 1'b1;
            if (sprite_complete()) r.sprite_end = 1'b1;
            else dec_phase = PH_RUNLO;
          end else begin
            dec_phase = PH_RED;
          end
        end
        default: dec_phase = PH_IDLE;  // stray byte while idle
      endcase
      if (r.sprite_end) dec_phase = PH_IDLE;
      if (r.has_pixel || r.sprite_end) decoded_q.push_back(r);
    end
  endtask

  // Idle length before the next item; runs of zero gaps come in bursts
  function automatic int unsigned draw_gap(inout int unsigned burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  // Byte driver: present queued bytes, predict on each accepted one
  int unsigned  src_gap   = 0;
  int unsigned  src_burst = 0;
  stream_byte_t next_byte;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tuser[0]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          next_byte = byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_byte.data;
          s_axis_tuser  <= next_byte.start;
          src_gap = draw_gap(src_burst);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Result monitor: compare each accepted item, then pace tready
  int unsigned sink_gap   = 0;
  int unsigned sink_burst = 0;
  int unsigned hold_left  = 0;
  sprite_out_t want_out;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          $error("output item with no predicted item pending");
          mismatch_cnt++;
        end else begin
          want_out = decoded_q.pop_front();
          check_field("has_pixel", 16'(want_out.has_pixel), 16'(m_axis_tuser[0]));
          check_field("pixel_x", 16'(want_out.pixel_x), 16'(m_axis_tdata[11:0]));
          check_field("pixel_y", 16'(want_out.pixel_y), 16'(m_axis_tdata[23:12]));
          check_field("red", 16'(want_out.red), 16'(m_axis_tdata[31:24]));
          check_field("green", 16'(want_out.green), 16'(m_axis_tdata[39:32]));
          check_field("blue", 16'(want_out.blue), 16'(m_axis_tdata[47:40]));
          check_field("sprite_end", 16'(want_out.sprite_end), 16'(m_axis_tlast));
          check_field("error_code", 16'(want_out.error_code), 16'(m_axis_tuser[2:1]));
        end
        result_cnt++;
        // back up the output for a long stretch so the input side stalls
        if (result_cnt == 40 || result_cnt == 3000) hold_left = HOLD_CYCLES;
        sink_gap = draw_gap(sink_burst);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when neither side moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic push(input logic [7:0] b, input logic start);
    byte_q.push_back({start, b});
  endtask

  task automatic push_word(input logic [15:0] w);
    push(w[7:0], 1'b0);
    push(w[15:8], 1'b0);
  endtask

  // Hold until every byte is taken and every predicted item has come out
  task automatic wait_idle();
    do @(negedge clk_i);
    while (byte_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_ORIGIN_X:    cfg_ox = val[10:0];
      REG_ORIGIN_Y:    cfg_oy = val[10:0];
      REG_MAX_PAYLOAD: cfg_max_size = val;
      REG_MAX_RUN:     cfg_max_run = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [10:0] ox, input logic [10:0] oy,
                            input logic [15:0] max_size, input logic [15:0] max_run);
    write_reg(REG_ORIGIN_X, 16'(ox));
    write_reg(REG_ORIGIN_Y, 16'(oy));
    write_reg(REG_MAX_PAYLOAD, max_size);
    write_reg(REG_MAX_RUN, max_run);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed sprites with random content, some cut short, some noise
  task automatic queue_random(input int unsigned n);
    logic [7:0]  body[$];
    int unsigned added, nruns, i, len, cap, size, kind, cut;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        repeat ($urandom_range(1, 4)) begin
          push(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
          added++;
        end
      end else begin
        body.delete();
        nruns = $urandom_range(1, 8);
        for (i = 0; i < nruns; i++) begin
          // even runs are transparent, odd runs solid
          if (i % 2 == 0) cap = (cfg_max_run < 48) ? cfg_max_run : 48;
          else cap = (cfg_max_run < 5) ? cfg_max_run : 5;
          len = $urandom_range(0, cap);
          if ($urandom_range(0, 29) == 0) begin
            if (cfg_max_run != 16'hFFFF) len = cfg_max_run + 1;
            else if (i % 2 == 0) len = $urandom_range(0, 65535);
          end
          body.push_back(len[7:0]);
          body.push_back(len[15:8]);
          if (i % 2 == 1 && len <= cfg_max_run) begin
            repeat (3 * len) body.push_back(8'($urandom_range(0, 255)));
          end
          if (len > cfg_max_run) break;
        end
        size = body.size();
        case ($urandom_range(0, 9))
          0: size = $urandom_range(0, body.size() + 3);
          1: if (cfg_max_size != 16'hFFFF) size = cfg_max_size + 1;
          default: ;
        endcase
        cut = body.size();
        if (kind <= 2 && cut > 0) cut = $urandom_range(0, cut - 1);
        push(size[7:0], 1'b1);
        push(size[15:8], 1'b0);
        for (i = 0; i < cut; i++) push(body[i], 1'b0);
        added += 2 + cut;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values: edge cases of the size and run checks
    @(negedge clk_i);
    push(8'hA5, 1'b0);                          // stray byte while idle
    push(8'h00, 1'b1); push(8'h00, 1'b0);       // size zero ends at once
    push(8'h01, 1'b1); push(8'h00, 1'b0);       // size one ends at once
    push(8'hAD, 1'b1); push(8'h0D, 1'b0);       // size 3501, too large
    push(8'h40, 1'b1);                          // dropped by the restart below
    push(8'd14, 1'b1); push(8'h00, 1'b0);
    push_word(16'd3); push_word(16'd0);         // empty solid run flips back
    push_word(16'd0); push_word(16'd2);
    push(8'hFF, 1'b0); push(8'h00, 1'b0); push(8'h80, 1'b0);
    push(8'h00, 1'b0); push(8'hFF, 1'b0); push(8'h7F, 1'b0);
    push(8'd16, 1'b1); push(8'h00, 1'b0);
    push_word(16'd3077);                        // run one above the limit
    queue_random(300);
    wait_idle();

    // Top extremes: origin at the far corner, limits wide open
    set_config(11'd2047, 11'd2047, 16'hFFFF, 16'hFFFF);
    @(negedge clk_i);
    push(8'd10, 1'b1); push(8'h00, 1'b0);
    push_word(16'hFFFF); push_word(16'd2);      // pixel index wraps to zero
    push(8'h12, 1'b0); push(8'h34, 1'b0); push(8'h56, 1'b0);
    push(8'hAB, 1'b0); push(8'hCD, 1'b0); push(8'hEF, 1'b0);
    queue_random(250);
    wait_idle();

    // Bottom extremes: every nonzero size and run is rejected
    set_config(11'd0, 11'd0, 16'd0, 16'd0);
    @(negedge clk_i);
    push(8'h00, 1'b1); push(8'h00, 1'b0);
    push(8'h01, 1'b1); push(8'h00, 1'b0);
    queue_random(100);
    wait_idle();

    // Random mid-range settings with tight run limits
    repeat (2) begin
      set_config(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                 16'($urandom_range(16, 400)), 16'($urandom_range(0, 12)));
      @(negedge clk_i);
      queue_random(175);
      wait_idle();
    end

    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sprite_rle_decoder.f @@
design/sre_pkg.sv
design/sprite_rle_decoder.sv
tb/sv/tb_top.sv
